/* hdl/rata_pkg.sv */
// Shared types, character constants and helpers for the radix string parser.
`timescale 1ns / 1ps

package rata_pkg;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_MALFORMED = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   // Decoded character: whether it is a digit of the current base, and its weight
   typedef struct packed {
      logic       valid;
      logic [5:0] weight;
   } digit_type;

   // Character codes
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   // Gaps closed so that letters follow the decimal digits
   localparam logic [7:0] UPPER_SKIP       = CHAR_UPPER_A - CHAR_NINE - 8'd1;
   localparam logic [7:0] LOWER_SKIP_FOLD  = CHAR_LOWER_A - CHAR_NINE - 8'd1;
   localparam logic [7:0] LOWER_SKIP_SPLIT = (CHAR_LOWER_A - CHAR_UPPER_Z - 8'd1)
                                             + UPPER_SKIP;

   // Base limits
   localparam logic [6:0] RADIX_MIN       = 7'd2;
   localparam logic [6:0] RADIX_MAX       = 7'd64;
   localparam logic [6:0] RADIX_ALNUM_MAX = 7'd36;
   localparam logic [6:0] RADIX_FOLD_MAX  = 7'd38;
   localparam logic [6:0] RADIX_RESET     = 7'd10;

   // True when the base is one the parser supports
   function automatic logic radix_ok(input logic [6:0] radix);
      return radix inside {[RADIX_MIN:RADIX_MAX]};
   endfunction

endpackage

/* hdl/rata_ifs.sv */
// Valid/ready channel interfaces for the request, response and register ports.
`timescale 1ns / 1ps

interface rata_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

interface rata_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic [1:0]  status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

interface rata_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] radix;

   modport source (output valid, output radix, input ready);
   modport sink   (input valid, input radix, output ready);
endinterface

/* hdl/rata_digit.sv */
// Character to digit weight decoder for bases 2 to 64.
`timescale 1ns / 1ps

module rata_digit (
   input  logic [7:0]         byte_in,
   input  logic [6:0]         radix,
   output rata_pkg::digit_type digit
);
   import rata_pkg::*;

   logic       in_class;
   logic [7:0] shifted;
   logic [7:0] zero_char;
   logic [7:0] offset;

   // Close the gaps between digits and letter ranges
   always_comb begin
      in_class = 1'b1;
      shifted  = byte_in;
      if (byte_in >= CHAR_LOWER_A) begin
         shifted = (radix <= RADIX_FOLD_MAX) ? byte_in - LOWER_SKIP_FOLD
                                             : byte_in - LOWER_SKIP_SPLIT;
      end else if (byte_in > CHAR_UPPER_Z) begin
         in_class = 1'b0;
      end else if (byte_in >= CHAR_UPPER_A) begin
         shifted = byte_in - UPPER_SKIP;
      end else if (byte_in > CHAR_NINE) begin
         in_class = 1'b0;
      end
   end

   // Rebase to the first digit character and check against the base
   assign zero_char = (radix > RADIX_ALNUM_MAX) ? CHAR_DOT : CHAR_ZERO;
   assign offset    = shifted - zero_char;

   assign digit.valid  = in_class && (shifted >= zero_char) &&
                         (offset < {1'b0, radix}) && radix_ok(radix);
   assign digit.weight = offset[5:0];

endmodule

/* hdl/radix_ascii_to_unsigned.sv */
`timescale 1ns / 1ps
// Top level of the radix string parser: NUL-terminated ASCII to unsigned 64-bit.
//
// Usage:
//   req_if  carries one character per word (byte_in); a zero byte ends a string.
//   rsp_if  carries one word per string: value and status (0 ok, 1 malformed,
//           empty or bad base, 2 overflow); value is zero unless status is ok.
//   csr_if  writes the radix register (2..64, reset 10); write it only while idle.
//           It is always ready.
// Timing:
//   Each character goes through an input register and then one multiply-add of
//   the accumulator by the radix (64 x 7 bits) and the digit weight, which sets
//   the clock period. One character per cycle is sustained while no terminator
//   waits for the response slot. A terminator loads the response register.
// Reset:
//   Synchronous, active high. Clears the accumulator, fault state, pending
//   words, and sets radix to 10.
// Backpressure:
//   A waiting response does not block characters of the next string; only a
//   second terminator stalls req_if until the response is taken.

module radix_ascii_to_unsigned (
   input  logic        clock,
   input  logic        reset,
   rata_req_if.sink    req_if,
   rata_rsp_if.source  rsp_if,
   rata_csr_if.sink    csr_if
);
   import rata_pkg::*;

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic [6:0]  radix_ff;
   logic [63:0] acc_ff, acc_in;
   logic        seen_ff, seen_in;
   status_type  fault_ff, fault_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_value_ff, rsp_value_in;
   status_type  rsp_status_ff, rsp_status_in;

   logic        slot_free;
   logic        s1_is_nul;
   logic        s1_fire;
   digit_type   digit;
   logic [70:0] product;
   logic [64:0] sum;
   logic        carry_out;
   status_type  final_status;

   // Handshake control
   assign slot_free     = !rsp_valid_ff || rsp_if.ready;
   assign s1_is_nul     = (s1_byte_ff == CHAR_NUL);
   assign s1_fire       = s1_valid_ff && (!s1_is_nul || slot_free);
   assign req_if.ready  = !s1_valid_ff || s1_fire;
   assign csr_if.ready  = 1'b1;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.value  = rsp_value_ff;
   assign rsp_if.status = rsp_status_ff;

   // Decode the held character
   rata_digit u_digit (
      .byte_in (s1_byte_ff),
      .radix   (radix_ff),
      .digit   (digit)
   );

   // Multiply-add with carry-out detection
   assign product   = 71'(acc_ff) * 71'(radix_ff);
   assign sum       = {1'b0, product[63:0]} + 65'(digit.weight);
   assign carry_out = (|product[70:64]) || sum[64];

   // Status of a string at its terminator
   always_comb begin
      final_status = fault_ff;
      if (fault_ff == STATUS_OK && (!seen_ff || !radix_ok(radix_ff))) begin
         final_status = STATUS_MALFORMED;
      end
   end

   // Advance the input stage
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_if.ready) begin
         s1_valid_in = req_if.valid;
      end
   end

   // Update accumulator and fault state
   always_comb begin
      acc_in   = acc_ff;
      seen_in  = seen_ff;
      fault_in = fault_ff;
      if (s1_fire) begin
         if (s1_is_nul) begin
            acc_in   = '0;
            seen_in  = 1'b0;
            fault_in = STATUS_OK;
         end else begin
            seen_in = 1'b1;
            if (fault_ff == STATUS_OK) begin
               if (!digit.valid) begin
                  fault_in = STATUS_MALFORMED;
               end else if (carry_out) begin
                  fault_in = STATUS_OVERFLOW;
               end else begin
                  acc_in = sum[63:0];
               end
            end
         end
      end
   end

   // Load or drop the response word
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (s1_fire && s1_is_nul) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = final_status;
         rsp_value_in  = (final_status == STATUS_OK) ? acc_ff : '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         radix_ff     <= RADIX_RESET;
         acc_ff       <= '0;
         seen_ff      <= 1'b0;
         fault_ff     <= STATUS_OK;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         seen_ff      <= seen_in;
         fault_ff     <= fault_in;
         if (csr_if.valid) begin
            radix_ff <= csr_if.radix;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         s1_byte_ff <= req_if.byte_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

/* hdl/rata_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the radix string parser, with its bind.

module rata_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_value,
   input logic [1:0]  rsp_status
);
   import rata_pkg::*;

   // Hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("response word changed while stalled");

   // Value is zero whenever the status reports a fault
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_value == 64'd0)
      else $error("nonzero value with fault status");

   // Status never carries the unused code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_MALFORMED) ||
                    (rsp_status == STATUS_OVERFLOW))
      else $error("unused status code");

   // Reset drops any pending response
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind radix_ascii_to_unsigned rata_checker u_rata_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_value  (rsp_if.value),
   .rsp_status (rsp_if.status)
);
